### src/rma_pkg.sv
// rma_pkg: shared types and constants for the room allocator
// scan item and write command carried along the row of room cells
// no dependencies
package rma_pkg;

    localparam int MAX_ROOMS_DEFAULT = 16;
    localparam int ROOM_COUNT_RESET  = 16;
    localparam int IDX_W             = 6;
    localparam int CNT_W             = 7;
    localparam int CFG_W             = 5;
    localparam int TIME_W            = 32;
    localparam int END_W             = 48;
    localparam int USES_W            = 32;

    typedef logic [IDX_W-1:0]  room_idx_t;
    typedef logic [CNT_W-1:0]  room_cnt_t;
    typedef logic [END_W-1:0]  end_val_t;
    typedef logic [USES_W-1:0] uses_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] start;
        logic              have_free;
        room_idx_t         free_idx;
        uses_t             free_uses;
        logic              have_min;
        end_val_t          min_end;
        room_idx_t         min_idx;
        uses_t             min_uses;
    } scan_pkt_t;

    typedef struct packed {
        logic      clear;
        logic      write;
        room_idx_t idx;
        end_val_t  end_val;
        uses_t     uses;
    } wr_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

### src/rma_cell.sv
// rma_cell: one room of the allocator chain
// holds end time, busy mark and use count; refines the passing scan item
// depends on rma_pkg
module rma_cell #(
    parameter int CELL_ID = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rma_pkg::room_cnt_t active_n,
    input  rma_pkg::wr_cmd_t   cmd,
    input  rma_pkg::scan_pkt_t pkt_in,
    output rma_pkg::scan_pkt_t pkt_out
);

    rma_pkg::end_val_t  end_reg;
    logic               busy_reg;
    rma_pkg::uses_t     uses_reg;
    rma_pkg::scan_pkt_t pkt_reg;
    rma_pkg::scan_pkt_t pkt_next;

    logic active;
    logic is_free;
    logic my_write;

    assign active   = rma_pkg::CNT_W'(CELL_ID) < active_n;
    assign is_free  = !busy_reg ||
                      (end_reg <= rma_pkg::END_W'(pkt_in.start));
    assign my_write = cmd.write && (cmd.idx == rma_pkg::IDX_W'(CELL_ID));

    always_comb
    begin
        pkt_next = pkt_in;
        if (active && !pkt_in.have_free && is_free)
        begin
            pkt_next.have_free = 1'b1;
            pkt_next.free_idx  = rma_pkg::IDX_W'(CELL_ID);
            pkt_next.free_uses = uses_reg;
        end
        if (active && (!pkt_in.have_min || (end_reg < pkt_in.min_end)))
        begin
            pkt_next.have_min = 1'b1;
            pkt_next.min_end  = end_reg;
            pkt_next.min_idx  = rma_pkg::IDX_W'(CELL_ID);
            pkt_next.min_uses = uses_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg  <= '0;
            busy_reg <= 1'b0;
            uses_reg <= '0;
        end
        else if (cmd.clear)
        begin
            end_reg  <= '0;
            busy_reg <= 1'b0;
            uses_reg <= '0;
        end
        else if (my_write)
        begin
            end_reg  <= cmd.end_val;
            busy_reg <= 1'b1;
            uses_reg <= cmd.uses;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

### src/room_allocator_with_delay.sv
// room_allocator_with_delay: top level of the meeting room allocator
// launches each item into a row of rma_cell rooms, resolves and writes back
// depends on rma_pkg and rma_cell
//
// Each request item is scanned through a row of MAX_ROOMS room cells, one
// cell per clock. The accepting edge loads the launch register; the item
// then passes the register of each cell in turn, the choice is resolved into
// the result register, and once the output is free the room is written back
// and the result registered. A new item is accepted once the previous one
// has been written back, even while its result still waits at the output.
// Setting first_of_batch clears every room and the use counts before that
// item is handled. room_count selects how many rooms take meetings; 0 acts
// as 1 and values above MAX_ROOMS act as MAX_ROOMS. Finish times saturate
// at 2^48-1.
module room_allocator_with_delay #(
    parameter int MAX_ROOMS = rma_pkg::MAX_ROOMS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                start_time,
    input  logic [31:0]                end_time,
    input  logic                       first_of_batch,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3:0]                 assigned_room,
    output logic [47:0]                finish_time,
    output logic                       delayed,
    output logic [3:0]                 most_used_room,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rma_pkg::CFG_W-1:0]  cfg_data
);

    rma_pkg::state_t    state_reg;
    rma_pkg::state_t    state_next;

    logic [rma_pkg::CFG_W-1:0] room_count_reg;
    rma_pkg::room_cnt_t        room_cnt_ext;
    rma_pkg::room_cnt_t        active_n;

    rma_pkg::scan_pkt_t launch_reg;
    rma_pkg::scan_pkt_t launch_next;
    rma_pkg::scan_pkt_t chain [MAX_ROOMS+1];
    rma_pkg::scan_pkt_t tail;
    rma_pkg::wr_cmd_t   cmd;

    logic [31:0]        dur_reg;
    logic [31:0]        free_fin_reg;

    rma_pkg::room_idx_t res_room_reg;
    rma_pkg::end_val_t  res_finish_reg;
    logic               res_late_reg;
    rma_pkg::uses_t     res_uses_reg;

    rma_pkg::room_idx_t res_room_next;
    rma_pkg::end_val_t  res_finish_next;
    rma_pkg::uses_t     chosen_uses;
    rma_pkg::uses_t     res_uses_next;
    logic [rma_pkg::END_W:0] late_sum;

    rma_pkg::room_idx_t best_room_reg;
    rma_pkg::uses_t     best_uses_reg;
    rma_pkg::room_idx_t best_room_next;
    rma_pkg::uses_t     best_uses_next;

    logic               out_valid_reg;
    logic [3:0]         out_room_reg;
    logic [47:0]        out_finish_reg;
    logic               out_late_reg;
    logic [3:0]         out_best_reg;

    logic accept;
    logic res_load;
    logic upd_fire;
    logic out_free;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_count_reg <= rma_pkg::CFG_W'(rma_pkg::ROOM_COUNT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            room_count_reg <= cfg_data;
        end
    end

    assign room_cnt_ext = rma_pkg::CNT_W'(room_count_reg);

    always_comb
    begin
        if (room_cnt_ext == '0)
            active_n = rma_pkg::CNT_W'(1);
        else if (room_cnt_ext > rma_pkg::CNT_W'(MAX_ROOMS))
            active_n = rma_pkg::CNT_W'(MAX_ROOMS);
        else
            active_n = room_cnt_ext;
    end

    // state machine
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rma_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = rma_pkg::ST_SCAN;
            end
            rma_pkg::ST_SCAN:
            begin
                if (tail.valid)
                    state_next = rma_pkg::ST_UPDATE;
            end
            rma_pkg::ST_UPDATE:
            begin
                if (out_free)
                    state_next = rma_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        res_load = 1'b0;
        upd_fire = 1'b0;
        unique case (state_reg)
            rma_pkg::ST_IDLE:   in_ready = 1'b1;
            rma_pkg::ST_SCAN:   res_load = tail.valid;
            rma_pkg::ST_UPDATE: upd_fire = out_free;
            default:            in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rma_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // launch
    always_comb
    begin
        launch_next       = '0;
        launch_next.valid = accept;
        launch_next.start = start_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            launch_reg <= '0;
        else
            launch_reg <= launch_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dur_reg      <= (end_time > start_time) ? (end_time - start_time) : 32'd0;
            free_fin_reg <= (end_time > start_time) ? end_time : start_time;
        end
    end

    // room cells
    always_comb
    begin
        cmd         = '0;
        cmd.clear   = accept && first_of_batch;
        cmd.write   = upd_fire;
        cmd.idx     = res_room_reg;
        cmd.end_val = res_finish_reg;
        cmd.uses    = res_uses_reg;
    end

    assign chain[0] = launch_reg;

    for (genvar g = 0; g < MAX_ROOMS; g++)
    begin : g_cell
        rma_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active_n (active_n),
            .cmd      (cmd),
            .pkt_in   (chain[g]),
            .pkt_out  (chain[g+1])
        );
    end

    assign tail = chain[MAX_ROOMS];

    // resolve
    always_comb
    begin
        late_sum = {1'b0, tail.min_end} + (rma_pkg::END_W+1)'(dur_reg);
        if (tail.have_free)
        begin
            res_room_next   = tail.free_idx;
            res_finish_next = rma_pkg::END_W'(free_fin_reg);
            chosen_uses     = tail.free_uses;
        end
        else
        begin
            res_room_next   = tail.min_idx;
            res_finish_next = late_sum[rma_pkg::END_W] ? '1 :
                              late_sum[rma_pkg::END_W-1:0];
            chosen_uses     = tail.min_uses;
        end
        res_uses_next = (chosen_uses == '1) ? chosen_uses :
                        chosen_uses + rma_pkg::USES_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_room_reg   <= res_room_next;
            res_finish_reg <= res_finish_next;
            res_late_reg   <= !tail.have_free;
            res_uses_reg   <= res_uses_next;
        end
    end

    // most used room
    always_comb
    begin
        best_room_next = best_room_reg;
        best_uses_next = best_uses_reg;
        if ((res_uses_reg > best_uses_reg) ||
            ((res_uses_reg == best_uses_reg) && (res_room_reg < best_room_reg)))
        begin
            best_room_next = res_room_reg;
            best_uses_next = res_uses_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_room_reg <= '0;
            best_uses_reg <= '0;
        end
        else if (cmd.clear)
        begin
            best_room_reg <= '0;
            best_uses_reg <= '0;
        end
        else if (upd_fire)
        begin
            best_room_reg <= best_room_next;
            best_uses_reg <= best_uses_next;
        end
    end

    // result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (upd_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            out_room_reg   <= res_room_reg[3:0];
            out_finish_reg <= res_finish_reg;
            out_late_reg   <= res_late_reg;
            out_best_reg   <= best_room_next[3:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign assigned_room  = out_room_reg;
    assign finish_time    = out_finish_reg;
    assign delayed        = out_late_reg;
    assign most_used_room = out_best_reg;

    // checks
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == rma_pkg::ST_SCAN))
        else $error("scan item left the chain outside the scan state");

    a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> out_valid_reg)
        else $error("write-back did not produce a result item");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear |=> (best_uses_reg >= $past(best_uses_reg)))
        else $error("best use count fell without a batch clear");

    a_no_write_with_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !cmd.clear)
        else $error("room write and batch clear in the same cycle");

endmodule
